// ----- hdl/led_packet_to_mono_block_decoder_top_assert.svh -----
// Assertion macros shared by the LED packet decoder modules.
// Each macro expects clk and rst to be visible where it is used.
`ifndef LED_PACKET_TO_MONO_BLOCK_DECODER_TOP_ASSERT_SVH
`define LED_PACKET_TO_MONO_BLOCK_DECODER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LED2M_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define LED2M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/led2m_pkg.sv -----
// Package for the LED packet to mono block decoder: payload types, codes, defaults.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package led2m_pkg;

  localparam int unsigned MAX_READ_BYTES_DEF = 1500;
  localparam int unsigned MAX_CELLS_DEF      = 256;

  localparam logic [10:0] INDEXED_LENGTH = 11'd1026;
  localparam logic [10:0] LENGTH_SAT     = 11'd2047;
  localparam logic [7:0]  THRESHOLD_RST  = 8'd40;

  // Configuration register indexes
  localparam logic REG_TARGET_SENDER = 1'b0;
  localparam logic REG_ON_THRESHOLD  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CELL  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Packet modes held in the front end
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_INDEXED = 2'd1;
  localparam logic [1:0] MODE_SEQ     = 2'd2;
  localparam logic [1:0] MODE_CTRL    = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [10:0] packet_length;
    logic [31:0] sender_addr;
    logic        final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] decode_mode;
    logic [4:0] cell_col;
    logic [2:0] cell_row;
    logic       cell_on;
    logic [2:0] fb_page;
    logic [6:0] fb_column;
    logic       upper_nibble;
    logic       last_result;
  } out_item_t;

  // One queued work entry: the first result, optionally followed by a frame end.
  typedef struct packed {
    logic [1:0] first_kind;
    logic       add_end;
    logic [1:0] decode_mode;
    logic [7:0] led_index;
    logic [9:0] color_sum;
  } work_t;

endpackage

// ----- hdl/led2m_front.sv -----
// Front end: accepts packet bytes, tracks packet state and builds work entries.
// Depends on led2m_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "led_packet_to_mono_block_decoder_top_assert.svh"

module led2m_front #(
  parameter int unsigned MAX_READ_BYTES = led2m_pkg::MAX_READ_BYTES_DEF,
  parameter int unsigned MAX_CELLS      = led2m_pkg::MAX_CELLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  led2m_pkg::in_item_t byte_data,
  input  logic [31:0]         target_sender,
  input  logic                queue_full,
  output logic                push,
  output led2m_pkg::work_t    push_data
);

  localparam logic [10:0] MaxRead  = 11'(MAX_READ_BYTES);
  localparam logic [8:0]  MaxCells = 9'(MAX_CELLS);

  logic [10:0] byte_position, byte_position_next;
  logic [1:0]  packet_mode, packet_mode_next;
  logic [1:0]  group_byte_index, group_byte_index_next;
  logic [7:0]  led_index, led_index_next;
  logic [9:0]  color_sum, color_sum_next;
  logic [8:0]  cells_done, cells_done_next;

  logic        accept;
  logic        has_result;
  logic [10:0] eff_len;
  logic [1:0]  mode_now;
  logic [9:0]  sum_add;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;
  assign push       = accept && has_result;

  always_comb begin
    byte_position_next    = byte_position;
    packet_mode_next      = packet_mode;
    group_byte_index_next = group_byte_index;
    led_index_next        = led_index;
    color_sum_next        = color_sum;
    cells_done_next       = cells_done;
    has_result            = 1'b0;
    push_data.first_kind  = led2m_pkg::KIND_CELL;
    push_data.add_end     = 1'b0;
    push_data.led_index   = led_index;
    push_data.color_sum   = 10'd0;

    eff_len  = (byte_data.packet_length < MaxRead) ? byte_data.packet_length : MaxRead;
    sum_add  = color_sum + {2'b00, byte_data.data_byte};
    mode_now = packet_mode;

    if (byte_position == 11'd0) begin
      // First byte: decide the packet
      group_byte_index_next = 2'd0;
      led_index_next        = 8'd0;
      color_sum_next        = 10'd0;
      cells_done_next       = 9'd0;
      mode_now              = led2m_pkg::MODE_IDLE;
      if ((target_sender == 32'd0 || byte_data.sender_addr == target_sender) &&
          eff_len > 11'd2) begin
        if (eff_len == led2m_pkg::INDEXED_LENGTH || byte_data.data_byte == 8'd0 ||
            byte_data.data_byte == 8'd1) begin
          mode_now = led2m_pkg::MODE_INDEXED;
        end else if (byte_data.data_byte == 8'd2) begin
          mode_now = led2m_pkg::MODE_SEQ;
        end else begin
          mode_now = led2m_pkg::MODE_CTRL;
        end
        has_result           = 1'b1;
        push_data.first_kind = led2m_pkg::KIND_START;
      end
      packet_mode_next = mode_now;
    end else if (byte_position >= 11'd2 && byte_position < eff_len &&
                 (packet_mode == led2m_pkg::MODE_INDEXED ||
                  packet_mode == led2m_pkg::MODE_SEQ) &&
                 cells_done < MaxCells) begin
      if (packet_mode == led2m_pkg::MODE_INDEXED) begin
        if (group_byte_index == 2'd0) begin
          led_index_next        = byte_data.data_byte;
          color_sum_next        = 10'd0;
          group_byte_index_next = 2'd1;
        end else if (group_byte_index == 2'd3) begin
          has_result            = 1'b1;
          push_data.color_sum   = sum_add;
          cells_done_next       = cells_done + 9'd1;
          group_byte_index_next = 2'd0;
          color_sum_next        = 10'd0;
        end else begin
          color_sum_next        = sum_add;
          group_byte_index_next = group_byte_index + 2'd1;
        end
      end else begin
        if (group_byte_index >= 2'd2) begin
          has_result            = 1'b1;
          push_data.led_index   = cells_done[7:0];
          push_data.color_sum   = sum_add;
          cells_done_next       = cells_done + 9'd1;
          group_byte_index_next = 2'd0;
          color_sum_next        = 10'd0;
        end else begin
          color_sum_next        = sum_add;
          group_byte_index_next = group_byte_index + 2'd1;
        end
      end
    end

    push_data.decode_mode = mode_now - 2'd1;

    if (byte_data.final_byte) begin
      // Close the packet; drop any partial group
      if (mode_now != led2m_pkg::MODE_IDLE) begin
        if (has_result) begin
          push_data.add_end = 1'b1;
        end else begin
          has_result           = 1'b1;
          push_data.first_kind = led2m_pkg::KIND_END;
        end
      end
      byte_position_next    = 11'd0;
      packet_mode_next      = led2m_pkg::MODE_IDLE;
      group_byte_index_next = 2'd0;
      led_index_next        = 8'd0;
      color_sum_next        = 10'd0;
      cells_done_next       = 9'd0;
    end else if (byte_position != led2m_pkg::LENGTH_SAT) begin
      byte_position_next = byte_position + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 11'd0;
      packet_mode      <= led2m_pkg::MODE_IDLE;
      group_byte_index <= 2'd0;
      led_index        <= 8'd0;
      color_sum        <= 10'd0;
      cells_done       <= 9'd0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      packet_mode      <= packet_mode_next;
      group_byte_index <= group_byte_index_next;
      led_index        <= led_index_next;
      color_sum        <= color_sum_next;
      cells_done       <= cells_done_next;
    end
  end

  `LED2M_ASSERT(a_idle_clean, packet_mode != led2m_pkg::MODE_IDLE || (cells_done == 9'd0 && group_byte_index == 2'd0), "idle packet holds group state")
  `LED2M_ASSERT_NEXT(a_final_rewinds, accept && byte_data.final_byte, byte_position == 11'd0 && packet_mode == led2m_pkg::MODE_IDLE, "final byte did not close the packet")

endmodule

// ----- hdl/led2m_queue.sv -----
// Two-entry queue of work entries between the front end and the back end.
// Depends on led2m_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "led_packet_to_mono_block_decoder_top_assert.svh"

module led2m_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  led2m_pkg::work_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output led2m_pkg::work_t head_data
);

  led2m_pkg::work_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `LED2M_ASSERT(a_queue_bounds, !(push && full) && !(pop && !head_valid) && count != 2'd3, "queue overrun or underrun")

endmodule

// ----- hdl/led2m_back.sv -----
// Back end: expands work entries into result transactions and maps cells to the display.
// Depends on led2m_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "led_packet_to_mono_block_decoder_top_assert.svh"

module led2m_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  led2m_pkg::work_t     head_data,
  output logic                 pop,
  input  logic [7:0]           on_threshold,
  output logic                 result_valid,
  input  logic                 result_stall,
  output led2m_pkg::out_item_t result_data
);

  logic                 phase;
  logic                 load;
  led2m_pkg::out_item_t item;
  logic [9:0]           on_limit;
  logic [1:0]           cur_kind;

  assign load = !result_valid || !result_stall;
  assign pop  = load && head_valid && (phase || !head_data.add_end);

  // avg = sum/3 exceeds thr exactly when sum exceeds 3*thr + 2
  assign on_limit = {1'b0, on_threshold, 1'b0} + {2'b00, on_threshold} + 10'd2;

  always_comb begin
    cur_kind = phase ? led2m_pkg::KIND_END : head_data.first_kind;
    item              = '0;
    item.kind         = cur_kind;
    item.decode_mode  = head_data.decode_mode;
    item.last_result  = phase || !head_data.add_end;
    if (cur_kind == led2m_pkg::KIND_CELL) begin
      // Panels run in reverse order; rows are flipped within a panel
      item.cell_col     = {~head_data.led_index[7:6], head_data.led_index[5:3]};
      item.cell_row     = ~head_data.led_index[2:0];
      item.cell_on      = head_data.color_sum > on_limit;
      item.fb_page      = 3'd2 + {1'b0, item.cell_row[2:1]};
      item.fb_column    = {item.cell_col, 2'b00};
      item.upper_nibble = item.cell_row[0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase        <= 1'b0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) begin
        phase <= !phase && head_data.add_end;
      end
    end
  end

  `LED2M_ASSERT(a_phase_has_end, !phase || (head_valid && head_data.add_end), "second result without an entry that needs it")

endmodule

// ----- hdl/led_packet_to_mono_block_decoder_top.sv -----
// Top level of the LED packet to mono block decoder: configuration registers and wiring.
// Depends on led2m_pkg, led2m_front, led2m_queue and led2m_back.
`timescale 1ns / 1ps

// Packet bytes enter at one per cycle while the queue is not full. The front end decides
// each packet on its first byte, gathers colour groups and queues one work entry per byte
// that yields results; a two-entry queue decouples it from the back end, which maps cells
// to the 32x8 matrix and the framebuffer and presents results through an output register.
// A byte yields at most two results (a frame start or cell update, then a frame end); the
// back end presents one result per cycle while result_stall is low, so bytes that yield
// two results can fill the queue. Configuration writes are always accepted.
module led_packet_to_mono_block_decoder_top #(
  parameter int unsigned MAX_READ_BYTES = led2m_pkg::MAX_READ_BYTES_DEF,
  parameter int unsigned MAX_CELLS      = led2m_pkg::MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  led2m_pkg::in_item_t  byte_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output led2m_pkg::out_item_t result_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0]      target_sender;
  logic [7:0]       on_threshold;
  logic             push;
  led2m_pkg::work_t push_data;
  logic             pop;
  logic             queue_full;
  logic             head_valid;
  led2m_pkg::work_t head_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sender <= 32'd0;
      on_threshold  <= led2m_pkg::THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        led2m_pkg::REG_TARGET_SENDER: target_sender <= cfg_data;
        led2m_pkg::REG_ON_THRESHOLD:  on_threshold  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  led2m_front #(
    .MAX_READ_BYTES(MAX_READ_BYTES),
    .MAX_CELLS     (MAX_CELLS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .target_sender(target_sender),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  led2m_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  led2m_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .on_threshold(on_threshold),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data)
  );

endmodule
